FILE: hdl/dag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_pkg
// Shared widths, register indexes, model codes and the exp2 constant table
// ----------------------------------------------------------------------------
package dag_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int DIST_W    = 31;
    localparam int ROLL_W    = 16;
    localparam int MODEL_W   = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    localparam logic [MODEL_W-1:0] MODEL_NONE = 2'd0;
    localparam logic [MODEL_W-1:0] MODEL_LIN  = 2'd1;
    localparam logic [MODEL_W-1:0] MODEL_INV  = 2'd2;
    localparam logic [MODEL_W-1:0] MODEL_EXP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODEL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 4'd3;

    localparam logic [MODEL_W-1:0] RST_MODEL = MODEL_INV;
    localparam logic [DIST_W-1:0]  RST_REF   = 31'd65536;
    localparam logic [DIST_W-1:0]  RST_MAX   = 31'h7FFF_FFFF;
    localparam logic [ROLL_W-1:0]  RST_ROLL  = 16'd256;

    // log2 unit: 5-bit integer part, LOG_STEPS fraction bits
    localparam int LOG_STEPS = 16;
    localparam int LOG_W     = 5 + LOG_STEPS;

    // exp2 unit
    localparam int EXP_STEPS = 16;
    localparam int ACC_W     = 31;
    localparam int CST_W     = 30;

    typedef logic [EXP_STEPS-1:0][CST_W-1:0] t_exp_tab;

    // entry i holds floor(2^(30 - 2^-(i+1))), built by repeated integer square roots
    function automatic t_exp_tab exp_table();
        t_exp_tab    tab;
        logic [63:0] cst;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        tab = '0;
        cst = 64'd1 << 29;
        for (int i = 0; i < EXP_STEPS; i++) begin
            v   = cst << 30;
            res = '0;
            bt  = 64'd1 << 62;
            while (bt > v) begin
                bt = bt >> 2;
            end
            while (bt != 64'd0) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            cst    = res;
            tab[i] = cst[CST_W-1:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = exp_table();

endpackage

FILE: hdl/dag_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_div
// Pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module dag_div import dag_pkg::*; #(
    parameter int NUM_W = 55,
    parameter int DEN_W = 48,
    parameter int QW    = 24
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QW-1:0]    o_quot
);

    logic [DEN_W-1:0] r_rem [QW];
    logic [DEN_W-1:0] r_den [QW];
    logic [QW-1:0]    r_lo  [QW];
    logic [QW-1:0]    r_q   [QW];

    logic [DEN_W-1:0] w_rem_in [QW];
    logic [DEN_W-1:0] w_den_in [QW];
    logic [QW-1:0]    w_lo_in  [QW];
    logic [QW-1:0]    w_q_in   [QW];
    logic [DEN_W:0]   w_t      [QW];
    logic [DEN_W:0]   w_dif    [QW];
    logic             w_ge     [QW];

    always_comb begin
        for (int i = 0; i < QW; i++) begin
            if (i == 0) begin
                w_rem_in[i] = DEN_W'(i_num[NUM_W-1:QW]);
                w_den_in[i] = i_den;
                w_lo_in[i]  = i_num[QW-1:0];
                w_q_in[i]   = '0;
            end else begin
                w_rem_in[i] = r_rem[i-1];
                w_den_in[i] = r_den[i-1];
                w_lo_in[i]  = r_lo[i-1];
                w_q_in[i]   = r_q[i-1];
            end
            w_t[i]   = {w_rem_in[i], w_lo_in[i][QW-1-i]};
            w_ge[i]  = (w_t[i] >= {1'b0, w_den_in[i]});
            w_dif[i] = w_t[i] - {1'b0, w_den_in[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QW; i++) begin
            r_rem[i] <= w_ge[i] ? w_dif[i][DEN_W-1:0] : w_t[i][DEN_W-1:0];
            r_q[i]   <= {w_q_in[i][QW-2:0], w_ge[i]};
            r_den[i] <= w_den_in[i];
            r_lo[i]  <= w_lo_in[i];
        end
    end

    assign o_quot = r_q[QW-1];

endmodule

FILE: hdl/dag_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_log2
// Pipelined log2 in Q.16: normalize stage, then one mantissa squaring per stage
// ----------------------------------------------------------------------------
module dag_log2 import dag_pkg::*; (
    input  logic              i_clk,
    input  logic [DIST_W-1:0] i_x,
    output logic [LOG_W-1:0]  o_log
);

    logic [4:0]        w_e;
    logic [30:0]       w_zn;
    logic [61:0]       w_sq [LOG_STEPS];
    logic [31:0]       w_t  [LOG_STEPS];

    logic [30:0]          r_z  [LOG_STEPS+1];
    logic [4:0]           r_e  [LOG_STEPS+1];
    logic [LOG_STEPS-1:0] r_fr [LOG_STEPS+1];

    // msb index and mantissa in Q1.30
    always_comb begin
        w_e = '0;
        for (int b = 1; b < DIST_W; b++) begin
            if (i_x[b]) begin
                w_e = 5'(b);
            end
        end
        w_zn = i_x << (5'd30 - w_e);
    end

    always_comb begin
        for (int k = 0; k < LOG_STEPS; k++) begin
            w_sq[k] = 62'(r_z[k]) * 62'(r_z[k]);
            w_t[k]  = w_sq[k][61:30];
        end
    end

    always_ff @(posedge i_clk) begin
        r_z[0]  <= w_zn;
        r_e[0]  <= w_e;
        r_fr[0] <= '0;
        for (int k = 0; k < LOG_STEPS; k++) begin
            r_e[k+1] <= r_e[k];
            if (w_t[k][31]) begin
                r_z[k+1]  <= w_t[k][31:1];
                r_fr[k+1] <= {r_fr[k][LOG_STEPS-2:0], 1'b1};
            end else begin
                r_z[k+1]  <= w_t[k][30:0];
                r_fr[k+1] <= {r_fr[k][LOG_STEPS-2:0], 1'b0};
            end
        end
    end

    assign o_log = {r_e[LOG_STEPS], r_fr[LOG_STEPS]};

endmodule

FILE: hdl/distance_attenuation_gain_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_attenuation_gain_top
// Clamped distance attenuation gain (none, linear, inverse, exponent)
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_source_distance (signed Q16.16) with start high; the word
//   is taken on a rising edge where start is high and busy is low. busy is
//   low whenever the block is out of reset, so one word can be taken every
//   cycle.
//   Output: o_gain (Q1.GAIN_FRAC_BITS) is shown for exactly one cycle with
//   o_valid high, in input order. Throughput is one word per cycle; the
//   exponent path holds the log2 and 16-stage exp2 pipelines, and the
//   divider path of the linear and inverse models is padded to match it.
//   Config: write register i_cfg_index with i_cfg_data on an edge where
//   i_cfg_valid and o_cfg_ready are high; write only while no word is in
//   flight. Indexes beyond the list are ignored.
//   Reset (i_rst_n low, synchronous) restores the default registers and
//   drops all words in flight. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module distance_attenuation_gain_top import dag_pkg::*; #(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [31:0]        i_source_distance,
    output logic                      o_valid,
    output logic [GAIN_FRAC_BITS:0]   o_gain,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int G      = GAIN_FRAC_BITS;
    localparam int QW     = G + 8;
    localparam int NUM_W  = G + 39;
    localparam int DEN_W  = 48;
    localparam int PAD    = 32 - QW;
    localparam int NSTG   = 38;
    localparam int P_W    = ROLL_W + DIST_W;
    localparam int E_W    = ROLL_W + LOG_W;
    localparam logic [G:0] ONE = {1'b1, {G{1'b0}}};

    // config registers
    logic [MODEL_W-1:0] r_model;
    logic [DIST_W-1:0]  r_ref;
    logic [DIST_W-1:0]  r_max;
    logic [ROLL_W-1:0]  r_roll;

    logic w_acc;
    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_acc       = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= RST_MODEL;
            r_ref   <= RST_REF;
            r_max   <= RST_MAX;
            r_roll  <= RST_ROLL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MODEL: r_model <= i_cfg_data[MODEL_W-1:0];
                REG_REF:   r_ref   <= i_cfg_data[DIST_W-1:0];
                REG_MAX:   r_max   <= i_cfg_data[DIST_W-1:0];
                REG_ROLL:  r_roll  <= i_cfg_data[ROLL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIST_W-1:0] w_m;
    logic [DIST_W-1:0] w_span;
    assign w_m    = (r_max > r_ref) ? r_max : r_ref;
    assign w_span = w_m - r_ref;

    // valid and unity-flag lines
    logic r_vl  [NSTG];
    logic r_one [NSTG];

    // stage 0: input word
    logic [DIST_W-1:0] r_d;
    // stage 1: clamp
    logic [DIST_W-1:0] r_c;
    logic [DIST_W-1:0] r_cr;
    logic [DIST_W-1:0] n_c;

    assign n_c = (r_d < w_m) ? r_d : w_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vl[k] <= 1'b0;
            end
        end else begin
            r_vl[0] <= w_acc;
            for (int k = 1; k < NSTG; k++) begin
                r_vl[k] <= r_vl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= i_source_distance[31] ? '0 : i_source_distance[30:0];
        r_c    <= n_c;
        r_cr   <= n_c - r_ref;
        r_one[0] <= 1'b1;
        r_one[1] <= (r_model == MODEL_NONE) || (r_d <= r_ref);
        for (int k = 2; k < NSTG; k++) begin
            r_one[k] <= r_one[k-1];
        end
    end

    // divider path: stage 2 product, stage 3 operands
    logic [P_W-1:0]   r_p;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] w_den_inv;

    assign w_den_inv = (DEN_W'(r_ref) << 8) + DEN_W'(r_p);

    always_ff @(posedge i_clk) begin
        r_p <= P_W'(r_roll) * P_W'(r_cr);
        if (r_model == MODEL_LIN) begin
            if (w_span == '0) begin
                r_num <= '0;
                r_den <= DEN_W'(1);
            end else begin
                r_num <= NUM_W'(r_p) << (G - 8);
                r_den <= DEN_W'(w_span);
            end
        end else begin
            if (w_den_inv == '0) begin
                r_num <= NUM_W'(ONE);
                r_den <= DEN_W'(1);
            end else begin
                r_num <= NUM_W'(r_ref) << (8 + G);
                r_den <= w_den_inv;
            end
        end
    end

    logic [QW-1:0] w_quot;

    dag_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QW    (QW)
    ) u_div (
        .i_clk  (i_clk),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_quot (w_quot)
    );

    logic [G:0] r_divg;
    always_ff @(posedge i_clk) begin
        if (r_model == MODEL_LIN) begin
            r_divg <= (w_quot >= QW'(ONE)) ? '0 : ONE - w_quot[G:0];
        end else begin
            r_divg <= w_quot[G:0];
        end
    end

    logic [G:0] w_divg_al;
    generate
        if (PAD == 0) begin : g_nopad
            assign w_divg_al = r_divg;
        end else begin : g_pad
            logic [G:0] r_pad [PAD];
            always_ff @(posedge i_clk) begin
                r_pad[0] <= r_divg;
                for (int k = 1; k < PAD; k++) begin
                    r_pad[k] <= r_pad[k-1];
                end
            end
            assign w_divg_al = r_pad[PAD-1];
        end
    endgenerate

    // exponent path
    logic [LOG_W-1:0] w_lc;
    logic [LOG_W-1:0] w_lr;

    dag_log2 u_log_c (
        .i_clk (i_clk),
        .i_x   (r_c),
        .o_log (w_lc)
    );

    dag_log2 u_log_r (
        .i_clk (i_clk),
        .i_x   (r_ref),
        .o_log (w_lr)
    );

    logic [LOG_W-1:0] w_diff;
    logic [E_W-1:0]   r_e;
    assign w_diff = (w_lc > w_lr) ? (w_lc - w_lr) : '0;

    always_ff @(posedge i_clk) begin
        r_e <= E_W'(r_roll) * E_W'(w_diff);
    end

    logic [ACC_W-1:0]     r_acc [EXP_STEPS];
    logic [EXP_STEPS-1:0] r_f   [EXP_STEPS];
    logic [E_W-25:0]      r_n   [EXP_STEPS];
    logic [ACC_W-1:0]     w_ain [EXP_STEPS];
    logic [EXP_STEPS-1:0] w_fin [EXP_STEPS];
    logic [E_W-25:0]      w_nin [EXP_STEPS];
    logic [60:0]          w_pr  [EXP_STEPS];

    always_comb begin
        for (int k = 0; k < EXP_STEPS; k++) begin
            if (k == 0) begin
                w_ain[k] = ACC_W'(1) << 30;
                w_fin[k] = r_e[23:8];
                w_nin[k] = r_e[E_W-1:24];
            end else begin
                w_ain[k] = r_acc[k-1];
                w_fin[k] = r_f[k-1];
                w_nin[k] = r_n[k-1];
            end
            w_pr[k] = 61'(w_ain[k]) * 61'(EXP_TAB[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < EXP_STEPS; k++) begin
            r_acc[k] <= w_fin[k][EXP_STEPS-1-k] ? w_pr[k][60:30] : w_ain[k];
            r_f[k]   <= w_fin[k];
            r_n[k]   <= w_nin[k];
        end
    end

    logic [G:0]       r_expg;
    logic [ACC_W-1:0] w_esh;
    assign w_esh = r_acc[EXP_STEPS-1] >>
                   (5'(30 - G) + r_n[EXP_STEPS-1][4:0]);

    always_ff @(posedge i_clk) begin
        if (r_n[EXP_STEPS-1] > (E_W-24)'(G)) begin
            r_expg <= '0;
        end else begin
            r_expg <= w_esh[G:0];
        end
    end

    // output select
    logic [G:0] r_gain;
    always_ff @(posedge i_clk) begin
        if (r_one[NSTG-2]) begin
            r_gain <= ONE;
        end else if (r_model == MODEL_EXP) begin
            r_gain <= (r_ref == '0) ? ONE : r_expg;
        end else begin
            r_gain <= w_divg_al;
        end
    end

    assign o_valid = r_vl[NSTG-1];
    assign o_gain  = r_gain;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##NSTG o_valid)
        else $error("result word missing after fixed latency");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gain <= ONE))
        else $error("gain above unity");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_model == MODEL_NONE) |-> (o_gain == ONE))
        else $error("model none must give unity");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for distance_attenuation_gain_top: a short directed
// table under the reset registers, then phases of random distances under
// many register settings (extremes included), each gain checked in order
// against a gain predictor that runs beside the block
// ----------------------------------------------------------------------------
module tb_top import dag_pkg::*; ();

    localparam int GF       = 16;
    localparam int LATENCY  = 38;
    localparam int WDOG_MAX = 4000;
    localparam int N_PHASES = 14;
    localparam int PHASE_N  = 120;
    localparam int N_DIR    = 12;

    typedef struct {
        logic signed [31:0] src;
        bit                 known;
        logic [GF:0]        gain;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [31:0]   i_source_distance = '0;
    logic                 o_valid;
    logic [GF:0]          o_gain;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    distance_attenuation_gain_top uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [MODEL_W-1:0] p_model;
    logic [30:0]        p_ref;
    logic [30:0]        p_max;
    logic [15:0]        p_roll;
    logic [63:0]        exp_cst [1:16];

    logic [GF:0] gain_q[$];
    int          errors = 0;
    int          quiet = 0;
    bit          no_idle = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_fix(input logic [31:0] x);
        int          e;
        logic [63:0] z, frac;
        e = 0;
        frac = 0;
        while (e < 31 && (x >> (e + 1)) != 0) e++;
        z = 64'(x) << (30 - e);
        for (int i = 0; i < 16; i++) begin
            z = (z * z) >> 30;
            frac = frac << 1;
            if (z >= (64'd1 << 31)) begin
                frac = frac | 1;
                z = z >> 1;
            end
        end
        return (64'(e) << 16) | frac;
    endfunction

    function automatic logic [GF:0] attenuate(input logic signed [31:0] src_dist);
        logic [63:0] d, r, m, c, lc, lr, diff, ex, n, acc, sh, t, den, span;
        d = src_dist[31] ? 64'd0 : 64'(src_dist);
        r = 64'(p_ref);
        m = (p_max > p_ref) ? 64'(p_max) : r;
        if (p_model == MODEL_NONE || d <= r) return 17'(1 << GF);
        c = (d < m) ? d : m;
        if (p_model == MODEL_LIN) begin
            span = m - r;
            if (span == 0) return 17'(1 << GF);
            t = ((64'(p_roll) * (c - r)) << (GF - 8)) / span;
            return (t >= (1 << GF)) ? 17'd0 : 17'((1 << GF) - t);
        end
        if (p_model == MODEL_INV) begin
            den = (r << 8) + 64'(p_roll) * (c - r);
            if (den == 0) return 17'(1 << GF);
            return 17'((r << (8 + GF)) / den);
        end
        if (r == 0) return 17'(1 << GF);
        lc   = log2_fix(32'(c));
        lr   = log2_fix(32'(r));
        diff = (lc > lr) ? lc - lr : 64'd0;
        ex   = 64'(p_roll) * diff;
        n    = ex >> 24;
        acc  = 64'd1 << 30;
        for (int i = 1; i <= 16; i++)
            if (ex[24 - i]) acc = (acc * exp_cst[i]) >> 30;
        sh = 64'(30 - GF) + n;
        if (sh > 62) return 17'd0;
        return 17'(acc >> sh);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (gain_q.size() == 0) begin
                $error("gain: unexpected word, actual %0d", o_gain);
                errors++;
            end else begin
                if (o_gain !== gain_q[0]) begin
                    $error("gain: expected %0d, actual %0d", gain_q[0], o_gain);
                    errors++;
                end
                void'(gain_q.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic idle_gap();
        while (!no_idle && $urandom_range(99) < 38) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send(input logic signed [31:0] src_dist, input bit known,
                        input logic [GF:0] gain);
        idle_gap();
        start <= 1'b1;
        i_source_distance <= src_dist;
        do @(posedge i_clk); while (busy);
        if (known && attenuate(src_dist) !== gain) begin
            $error("gain: table expected %0d, predictor %0d", gain, attenuate(src_dist));
            errors++;
        end
        gain_q.push_back(known ? gain : attenuate(src_dist));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (gain_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODEL: p_model = data[MODEL_W-1:0];
            REG_REF:   p_ref   = data[30:0];
            REG_MAX:   p_max   = data[30:0];
            REG_ROLL:  p_roll  = data[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_dist();
        logic [31:0] hi;
        hi = (p_max > p_ref) ? 32'(p_max) : 32'(p_ref);
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'(p_ref) + $urandom_range(3) - 1;
            2: return hi + $urandom_range(3) - 1;
            3: return 32'h8000_0000 | $urandom;
            default: return (hi == 0) ? $urandom : 32'($urandom) % (hi + 32'd2);
        endcase
    endfunction

    function automatic logic [31:0] pick_distreg();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            3: return 32'($urandom_range(1, 8)) << 16;
            default: return 32'($urandom_range(1, 4000)) << $urandom_range(0, 16);
        endcase
    endfunction

    t_dir_row dir_tab [N_DIR] = '{
        '{32'sh8000_0000, 1, 17'd65536},
        '{-32'sd1,        1, 17'd65536},
        '{32'sd0,         1, 17'd65536},
        '{32'sd65536,     1, 17'd65536},
        '{32'sd65537,     0, 17'd0},
        '{32'sd131072,    1, 17'd32768},
        '{32'sd262144,    1, 17'd16384},
        '{32'sd655360,    0, 17'd0},
        '{32'sh7FFF_FFFF, 0, 17'd0},
        '{32'sh5555_5555, 0, 17'd0},
        '{32'sh2AAA_AAAA, 0, 17'd0},
        '{32'sh0000_FFFF, 1, 17'd65536}
    };

    initial begin
        logic [63:0] cst;
        cst = 64'd1 << 29;
        for (int i = 1; i <= 16; i++) begin
            cst = int_sqrt(cst << 30);
            exp_cst[i] = cst;
        end
        p_model = MODEL_INV;
        p_ref   = 31'd65536;
        p_max   = 31'h7FFF_FFFF;
        p_roll  = 16'd256;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) send(dir_tab[k].src, dir_tab[k].known, dir_tab[k].gain);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            // first phases walk every model, later ones pick it at random
            write_reg(REG_MODEL, (ph < 4) ? 32'(ph) : $urandom);
            case (ph % 4)
                0: begin
                    write_reg(REG_REF, 32'd0);
                    write_reg(REG_MAX, 32'h7FFF_FFFF);
                    write_reg(REG_ROLL, 32'hFFFF);
                end
                1: begin
                    write_reg(REG_REF, 32'h7FFF_FFFF);
                    write_reg(REG_MAX, 32'd0);
                    write_reg(REG_ROLL, 32'd0);
                end
                default: begin
                    write_reg(REG_REF, pick_distreg());
                    write_reg(REG_MAX, pick_distreg());
                    write_reg(REG_ROLL, $urandom);
                end
            endcase
            // unmapped index must be ignored
            write_reg(CFG_IDX_W'($urandom_range(4, 15)), $urandom);
            i_cfg_valid <= 1'b0;
            no_idle = (ph == 6);
            for (int k = 0; k < PHASE_N; k++) send(pick_dist(), 0, '0);
            no_idle = 0;
        end

        settle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
